[hw/rtl/csl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

   localparam int WAYS = 4;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam int TAG_W = 32;
   localparam int STAMP_W = 32;
   localparam int WAY_OUT_W = 6;
   localparam int CYCLES_W = 18;
   localparam int BLOCK_W = 13;
   localparam int CSR_INDEX_W = 2;

   localparam int XFER_WORD_SHIFT = 2;
   localparam int XFER_CYCLES_PER_WORD = 100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REPLACE_LRU   = 2'd0,
      CSR_WRITE_THROUGH = 2'd1,
      CSR_BLOCK_BYTES   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic                replace_lru;
      logic                write_through;
      logic [BLOCK_W-1:0]  block_bytes;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/csl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module csl_ctrl
   import csl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The next access may enter while this one commits its update.
            state_in = start ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.update  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOKUP: begin
            busy       = 1'b1;
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
         end
      endcase
      cmd.capture = start && !busy;
   end

endmodule

`default_nettype wire

[hw/rtl/csl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module csl_datapath
   import csl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire cfg_type               cfg,
   input  wire logic [TAG_W-1:0]      req_tag,
   input  wire logic [STAMP_W-1:0]    req_time_now,
   input  wire logic                  req_is_store,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [WAY_OUT_W-1:0]       rsp_way_used,
   output logic                       rsp_wrote_back,
   output logic [CYCLES_W-1:0]        rsp_mem_cycles
);

   localparam int XFER_W = CYCLES_W;

   // Per-way state.
   logic [WAYS-1:0]     valid_ff;
   logic [WAYS-1:0]     dirty_ff;
   logic [TAG_W-1:0]    tag_ff   [WAYS];
   logic [STAMP_W-1:0]  stamp_ff [WAYS];

   // Captured access.
   logic [TAG_W-1:0]    acc_tag_ff;
   logic [STAMP_W-1:0]  acc_now_ff;
   logic                acc_store_ff;

   // Lookup results.
   logic                hit_ff;
   logic [WAY_W-1:0]    way_ff;

   // Result registers.
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [WAY_W-1:0]    rsp_way_ff;
   logic                rsp_wb_ff;
   logic [CYCLES_W-1:0] rsp_cycles_ff;

   logic                hit_any;
   logic [WAY_W-1:0]    hit_idx;
   logic                inv_any;
   logic [WAY_W-1:0]    inv_idx;
   logic [WAY_W-1:0]    old_idx;
   logic [WAY_W-1:0]    way_in;

   logic                mark_dirty;
   logic                wb;
   logic [XFER_W-1:0]   xfer;
   logic [CYCLES_W:0]   cycles_sum;
   logic [CYCLES_W-1:0] cycles;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_tag_ff   <= req_tag;
         acc_now_ff   <= req_time_now;
         acc_store_ff <= req_is_store;
      end
   end

   // Tag compare, first invalid way and oldest valid way, lowest index first.
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      inv_any = 1'b0;
      inv_idx = '0;
      old_idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == acc_tag_ff)) begin
            hit_any = 1'b1;
            hit_idx = WAY_W'(i);
         end
         if (!valid_ff[i]) begin
            inv_any = 1'b1;
            inv_idx = WAY_W'(i);
         end
      end
      for (int i = 1; i < WAYS; i++) begin
         if (stamp_ff[i] < stamp_ff[old_idx]) begin
            old_idx = WAY_W'(i);
         end
      end
      if (hit_any) begin
         way_in = hit_idx;
      end else if (inv_any) begin
         way_in = inv_idx;
      end else begin
         way_in = old_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff <= hit_any;
         way_ff <= way_in;
      end
   end

   always_comb begin
      mark_dirty = acc_store_ff && !cfg.write_through;
      wb         = valid_ff[way_ff] && dirty_ff[way_ff] && !cfg.write_through;
      xfer       = XFER_W'(cfg.block_bytes >> XFER_WORD_SHIFT) *
                   XFER_W'(XFER_CYCLES_PER_WORD);
      // A write-back doubles the charge, which can pass the field range and then saturates.
      cycles_sum = wb ? ({1'b0, xfer} + {1'b0, xfer}) : {1'b0, xfer};
      cycles     = cycles_sum[CYCLES_W] ? '1 : cycles_sum[CYCLES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < WAYS; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         if (hit_ff) begin
            if (cfg.replace_lru) begin
               stamp_ff[way_ff] <= acc_now_ff;
            end
            if (mark_dirty) begin
               dirty_ff[way_ff] <= 1'b1;
            end
         end else begin
            stamp_ff[way_ff] <= acc_now_ff;
            valid_ff[way_ff] <= 1'b1;
            dirty_ff[way_ff] <= mark_dirty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && !hit_ff) begin
         tag_ff[way_ff] <= acc_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff    <= hit_ff;
         rsp_way_ff    <= way_ff;
         rsp_wb_ff     <= !hit_ff && wb;
         rsp_cycles_ff <= hit_ff ? '0 : cycles;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = WAY_OUT_W'(rsp_way_ff);
   assign rsp_wrote_back = rsp_wb_ff;
   assign rsp_mem_cycles = rsp_cycles_ff;

   a_rsp_follows_update : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.update))
      else $error("response beat without a preceding update");

   a_hit_is_free : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_cycles_ff == '0 && !rsp_wb_ff))
      else $error("hit charged memory cycles or a write-back");

   a_used_way_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> valid_ff[rsp_way_ff])
      else $error("reported way is not valid after the access");

   a_wb_costs_two : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wb_ff) |-> (rsp_cycles_ff[0] == 1'b0 || rsp_cycles_ff == '1))
      else $error("write-back charge is not two equal transfers");

endmodule

`default_nettype wire

[hw/rtl/cache_set_lookup_replace.sv]
`timescale 1ns / 1ps
`default_nettype none

// One set of a set-associative cache with LRU or FIFO replacement.
// Access channel: drive req_tag, req_time_now and req_is_store with start
// high; the access is taken at a rising edge where start is high and busy is
// low. Each access returns one response beat: rsp_valid is high for exactly
// one cycle with rsp_hit, rsp_way_used, rsp_wrote_back and rsp_mem_cycles.
// The response beat follows the lookup state, which registers the parallel
// tag compare and victim choice, and the update state. A new access may be
// accepted in the update state of the previous one, as busy is high only in
// the compare state; the update of one access and the capture of the next
// share an edge. The receiver cannot stall, and the beat is not held for it.
// Configuration: csr_valid/csr_ready write csr_wdata into register csr_index
// (0 replace_lru, 1 write_through, 2 block_bytes); csr_ready is always high.
// Write only while no access is in flight.
// Reset (synchronous, active high) clears all valid, dirty and stamp state,
// returns to idle and loads replace_lru=1, write_through=0, block_bytes=16.
module cache_set_lookup_replace
   import csl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [TAG_W-1:0]      req_tag,
   input  wire logic [STAMP_W-1:0]    req_time_now,
   input  wire logic                  req_is_store,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [WAY_OUT_W-1:0]       rsp_way_used,
   output logic                       rsp_wrote_back,
   output logic [CYCLES_W-1:0]        rsp_mem_cycles,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BLOCK_W-1:0]    csr_wdata
);

   cfg_type cfg_ff;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.replace_lru   <= 1'b1;
         cfg_ff.write_through <= 1'b0;
         cfg_ff.block_bytes   <= BLOCK_W'(16);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REPLACE_LRU:   cfg_ff.replace_lru   <= csr_wdata[0];
            CSR_WRITE_THROUGH: cfg_ff.write_through <= csr_wdata[0];
            CSR_BLOCK_BYTES:   cfg_ff.block_bytes   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   csl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   csl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg_ff),
      .req_tag        (req_tag),
      .req_time_now   (req_time_now),
      .req_is_store   (req_is_store),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_wrote_back (rsp_wrote_back),
      .rsp_mem_cycles (rsp_mem_cycles)
   );

endmodule

`default_nettype wire
